// ----- rtl/irfe_pkg.sv -----
// ----------------------------------------------------------------------------
// irfe_pkg - IR remote frame encoder package
// Protocol and status codes, timing constants and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package irfe_pkg;

  // Protocol codes
  localparam logic [3:0] PROTO_NEC      = 4'd0;
  localparam logic [3:0] PROTO_NECEXT   = 4'd1;
  localparam logic [3:0] PROTO_SAMSUNG  = 4'd2;
  localparam logic [3:0] PROTO_SIRC12   = 4'd3;
  localparam logic [3:0] PROTO_SIRC15   = 4'd4;
  localparam logic [3:0] PROTO_SIRC20   = 4'd5;
  localparam logic [3:0] PROTO_RCA      = 4'd6;
  localparam logic [3:0] PROTO_RC5      = 4'd7;
  localparam logic [3:0] PROTO_RC6      = 4'd8;
  localparam logic [3:0] PROTO_KASEIKYO = 4'd9;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVF    = 2'd1;
  localparam logic [1:0] ST_UNSUP  = 2'd2;

  // Register map
  localparam logic REG_MAX_DUR = 1'b0;

  // Reset value of the capacity register
  localparam logic [7:0] MAX_DUR_RESET = 8'd255;

  // Durations in microseconds
  localparam logic [13:0] T_9000 = 14'd9000;
  localparam logic [13:0] T_4500 = 14'd4500;
  localparam logic [13:0] T_2250 = 14'd2250;
  localparam logic [13:0] T_560  = 14'd560;
  localparam logic [13:0] T_1690 = 14'd1690;
  localparam logic [13:0] T_550  = 14'd550;
  localparam logic [13:0] T_1650 = 14'd1650;
  localparam logic [13:0] T_2400 = 14'd2400;
  localparam logic [13:0] T_600  = 14'd600;
  localparam logic [13:0] T_1200 = 14'd1200;
  localparam logic [13:0] T_4000 = 14'd4000;
  localparam logic [13:0] T_500  = 14'd500;
  localparam logic [13:0] T_1000 = 14'd1000;
  localparam logic [13:0] T_2000 = 14'd2000;
  localparam logic [13:0] T_3456 = 14'd3456;
  localparam logic [13:0] T_1728 = 14'd1728;
  localparam logic [13:0] T_432  = 14'd432;
  localparam logic [13:0] T_1296 = 14'd1296;
  localparam logic [13:0] T_2666 = 14'd2666;
  localparam logic [13:0] T_889  = 14'd889;
  localparam logic [9:0]  HALF_RC5 = 10'd889;
  localparam logic [9:0]  HALF_RC6 = 10'd444;

  // Half-bit counts of the Manchester frames
  localparam logic [5:0] NH_RC5 = 6'd28;
  localparam logic [5:0] NH_RC6 = 6'd44;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load;        // capture a new message
    logic       restart;     // rewind the duration walker, latch count
    logic       run;         // step the duration walker
    logic       emit;        // walker feeds the result register
    logic       err_load;    // load an error result
    logic [1:0] err_code;
  } irfe_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic unsup;      // captured protocol is not supported
    logic gen_done;   // walker has produced every duration
    logic cnt_bad;    // duration count is zero or above capacity
    logic out_free;   // result register can take a result
    logic last_sent;  // final result loaded this cycle
  } irfe_sts_t;

endpackage

`default_nettype wire

// ----- rtl/irfe_if.sv -----
// ----------------------------------------------------------------------------
// irfe_if - IR remote frame encoder channels
// Valid/ready channels for messages in and duration pairs out.
// ----------------------------------------------------------------------------
`default_nettype none

interface irfe_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  protocol;
  logic [23:0] address;
  logic [23:0] command;
  logic        repeat_req;

  modport source (output valid, protocol, address, command, repeat_req, input ready);
  modport sink   (input valid, protocol, address, command, repeat_req, output ready);
endinterface

interface irfe_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] mark_us;
  logic [12:0] space_us;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, mark_us, space_us, last, status, input ready);
  modport sink   (input valid, mark_us, space_us, last, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/irfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// irfe_ctrl - IR remote frame encoder controller
// Sequences capture, counting pass, capacity check and emission pass.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_ctrl import irfe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  output logic           in_ready,
  output irfe_cmd_t      cmd,
  input  wire irfe_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_COUNT, S_CHECK, S_EMIT, S_ERR} state_t;

  state_t     state_r, state_nxt;
  logic [1:0] err_code_r, err_code_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    err_code_nxt = err_code_r;
    cmd          = '0;
    cmd.err_code = err_code_r;
    // no item is taken while reset is held
    in_ready     = (state_r == S_IDLE) && rst_n;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        if (sts.unsup) begin
          err_code_nxt = ST_UNSUP;
          state_nxt    = S_ERR;
        end else if (sts.gen_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.run = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.cnt_bad) begin
          err_code_nxt = ST_OVF;
          state_nxt    = S_ERR;
        end else begin
          cmd.restart = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.run  = 1'b1;
        cmd.emit = 1'b1;
        if (sts.last_sent) state_nxt = S_IDLE;
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.err_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      err_code_r <= ST_OK;
    end else begin
      state_r    <= state_nxt;
      err_code_r <= err_code_nxt;
    end
  end

  // Error code is only ever one of the two failure codes in the error state
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ERR |-> (err_code_r == ST_OVF || err_code_r == ST_UNSUP))
    else $error("irfe_ctrl: bad error code");
  // Emission never starts after a failed check
  a_check_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && sts.cnt_bad) |=> state_r == S_ERR)
    else $error("irfe_ctrl: emission after failed check");
  // A new message is taken only while idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE)
    else $error("irfe_ctrl: load outside idle");

endmodule

`default_nettype wire

// ----- rtl/irfe_dp.sv -----
// ----------------------------------------------------------------------------
// irfe_dp - IR remote frame encoder datapath
// Message capture, duration walker, mark/space pairing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module irfe_dp import irfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire irfe_cmd_t   cmd,
  output irfe_sts_t        sts,
  input  wire logic [7:0]  max_dur,
  input  wire logic [3:0]  in_protocol,
  input  wire logic [23:0] in_address,
  input  wire logic [23:0] in_command,
  input  wire logic        in_repeat_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_mark_us,
  output logic [12:0]      out_space_us,
  output logic             out_last,
  output logic [1:0]       out_status
);

  typedef enum logic [2:0] {K_NONE, K_PD, K_SIRC, K_REP, K_MAN} kind_t;

  // Captured message
  logic [47:0] frame_bits_r, frame_bits_nxt;
  logic [43:0] half_r, half_nxt;
  logic [3:0]  proto_r;
  logic        rep_r;

  // Walker state
  logic [6:0]  j_r;       // durations produced so far
  logic [5:0]  mi_r;      // Manchester half index
  logic [2:0]  units_r;   // half-bits in current run
  logic        cur_r;     // level of current run
  logic [6:0]  cnt_r;     // total durations of the frame
  logic [13:0] mark_r;

  logic        out_valid_r;
  logic [13:0] out_mark_r;
  logic [12:0] out_space_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;

  // Frame bits and Manchester levels for a new message
  always_comb begin
    logic [3:0]  ra;
    logic [7:0]  a8, c8;
    logic [23:0] raw;
    logic [13:0] v14;
    logic [15:0] v16;
    ra  = in_address[3:0];
    a8  = in_address[7:0];
    c8  = in_command[7:0];
    raw = {ra, c8, ~ra, ~c8};
    // start, S2, toggle (always 0), address, command
    v14 = {1'b1, ~in_command[6], 1'b0, in_address[4:0], in_command[5:0]};
    v16 = {a8, c8};
    frame_bits_nxt = '0;
    half_nxt       = '0;
    case (in_protocol)
      PROTO_NEC:    frame_bits_nxt = {16'd0, ~c8, c8, ~a8, a8};
      PROTO_NECEXT: frame_bits_nxt = {16'd0, in_command[15:0], in_address[15:0]};
      PROTO_SAMSUNG: frame_bits_nxt = {16'd0, ~c8, c8, a8, a8};
      PROTO_SIRC12, PROTO_SIRC15, PROTO_SIRC20:
        frame_bits_nxt = {17'd0, in_address, in_command[6:0]};
      PROTO_RCA: begin
        for (int i = 0; i < 24; i++) frame_bits_nxt[23 - i] = raw[i];
      end
      PROTO_RC5: begin
        frame_bits_nxt = {34'd0, v14};
        for (int i = 0; i < 14; i++) begin
          half_nxt[2*i]     = ~v14[13 - i];
          half_nxt[2*i + 1] = v14[13 - i];
        end
      end
      PROTO_RC6: begin
        frame_bits_nxt = {32'd0, v16};
        half_nxt[11:0] = 12'b1100_1010_1001;
        for (int i = 0; i < 16; i++) begin
          half_nxt[12 + 2*i] = v16[15 - i];
          half_nxt[13 + 2*i] = ~v16[15 - i];
        end
      end
      PROTO_KASEIKYO: frame_bits_nxt = {in_command, in_address};
      default: frame_bits_nxt = '0;
    endcase
  end

  // Protocol timing selection
  kind_t       kind;
  logic [13:0] hm, hs, mk, s0, s1, stp;
  logic [5:0]  nb;
  logic [5:0]  nh;
  logic [9:0]  half_us;
  always_comb begin
    kind = K_NONE;
    hm = T_9000; hs = T_4500; mk = T_560; s0 = T_560; s1 = T_1690; stp = T_560;
    nb = 6'd32; nh = NH_RC5; half_us = HALF_RC5;
    case (proto_r)
      PROTO_NEC, PROTO_NECEXT: kind = rep_r ? K_REP : K_PD;
      PROTO_SAMSUNG: begin
        kind = K_PD;
        hm = T_4500; mk = T_550; s0 = T_550; s1 = T_1650; stp = T_550;
      end
      PROTO_SIRC12: begin kind = K_SIRC; nb = 6'd12; end
      PROTO_SIRC15: begin kind = K_SIRC; nb = 6'd15; end
      PROTO_SIRC20: begin kind = K_SIRC; nb = 6'd20; end
      PROTO_RCA: begin
        kind = K_PD; nb = 6'd24;
        hm = T_4000; hs = T_4000; mk = T_500; s0 = T_1000; s1 = T_2000; stp = T_500;
      end
      PROTO_RC5: kind = K_MAN;
      PROTO_RC6: begin kind = K_MAN; nh = NH_RC6; half_us = HALF_RC6; end
      PROTO_KASEIKYO: begin
        kind = K_PD; nb = 6'd48;
        hm = T_3456; hs = T_1728; mk = T_432; s0 = T_432; s1 = T_1296; stp = T_432;
      end
      default: kind = K_NONE;
    endcase
  end

  // Duration walker: one duration per step for bit-timed protocols,
  // one half-bit per step for Manchester run merging
  logic        g_done, g_emit;
  logic [13:0] g_dur;
  logic [6:0]  k;
  logic        dbit;
  logic [6:0]  len;
  logic        lvl;
  logic [5:0]  mi_nxt;
  logic [2:0]  units_nxt;
  logic        cur_nxt;
  logic [13:0] run_us;
  always_comb begin
    k         = j_r - 7'd2;
    dbit      = frame_bits_r[k[6:1]];
    lvl       = half_r[mi_r];
    run_us    = 14'(units_r * half_us);
    len       = 7'd0;
    g_done    = 1'b0;
    g_emit    = 1'b0;
    g_dur     = '0;
    mi_nxt    = mi_r;
    units_nxt = units_r;
    cur_nxt   = cur_r;
    case (kind)
      K_REP: begin
        len   = 7'd3;
        g_dur = (j_r == 7'd0) ? T_9000 : (j_r == 7'd1) ? T_2250 : T_560;
      end
      K_PD: begin
        len = {nb, 1'b0} + 7'd3;
        if (j_r == 7'd0)                g_dur = hm;
        else if (j_r == 7'd1)           g_dur = hs;
        else if (k < {nb, 1'b0})        g_dur = !k[0] ? mk : (dbit ? s1 : s0);
        else                            g_dur = stp;
      end
      K_SIRC: begin
        len = {nb, 1'b0} + 7'd1;
        if (j_r == 7'd0)                g_dur = T_2400;
        else if (j_r == 7'd1 || k[0])   g_dur = T_600;
        else                            g_dur = dbit ? T_1200 : T_600;
      end
      default: len = 7'd0;
    endcase

    if (kind == K_MAN) begin
      if (proto_r == PROTO_RC6 && j_r < 7'd2 && mi_r == 6'd0) begin
        g_emit = 1'b1;
        g_dur  = (j_r == 7'd0) ? T_2666 : T_889;
      end else if (mi_r == nh) begin
        if (units_r != 3'd0 && cur_r) begin
          g_emit    = 1'b1;
          g_dur     = run_us;
          units_nxt = 3'd0;
        end else begin
          g_done = 1'b1;
        end
      end else begin
        mi_nxt = mi_r + 6'd1;
        if (units_r == 3'd0) begin
          if (lvl) begin
            cur_nxt   = 1'b1;
            units_nxt = 3'd1;
          end
        end else if (lvl == cur_r) begin
          units_nxt = units_r + 3'd1;
        end else begin
          g_emit    = 1'b1;
          g_dur     = run_us;
          cur_nxt   = lvl;
          units_nxt = 3'd1;
        end
      end
    end else begin
      g_done = (j_r == len);
      g_emit = !g_done;
    end
  end

  // Step control and result load
  logic       stall, adv, res_load, res_last;
  logic [6:0] last_idx;
  assign stall    = cmd.emit && out_valid_r && !out_ready;
  assign adv      = cmd.run && !stall && !g_done;
  assign last_idx = cnt_r - 7'd1;
  assign res_last = (j_r == last_idx);
  assign res_load = adv && cmd.emit && g_emit && (j_r[0] || res_last);

  assign sts.unsup     = (kind == K_NONE);
  assign sts.gen_done  = g_done;
  assign sts.cnt_bad   = (j_r == 7'd0) || ({1'b0, j_r} > max_dur);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.last_sent = res_load && res_last;

  // Message capture and walker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r <= '0;
      half_r       <= '0;
      proto_r      <= '0;
      rep_r        <= 1'b0;
      j_r          <= '0;
      mi_r         <= '0;
      units_r      <= '0;
      cur_r        <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cmd.load) begin
        frame_bits_r <= frame_bits_nxt;
        half_r       <= half_nxt;
        proto_r      <= in_protocol;
        rep_r        <= in_repeat_req;
      end
      if (cmd.load || cmd.restart) begin
        j_r     <= '0;
        mi_r    <= '0;
        units_r <= '0;
        cur_r   <= 1'b0;
      end else if (adv) begin
        mi_r    <= mi_nxt;
        units_r <= units_nxt;
        cur_r   <= cur_nxt;
        if (g_emit) j_r <= j_r + 7'd1;
      end
      if (cmd.restart) cnt_r <= j_r;
    end
  end

  // Held mark waiting for its space
  always_ff @(posedge clk) begin
    if (adv && cmd.emit && g_emit && !j_r[0]) mark_r <= g_dur;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load || cmd.err_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      out_mark_r   <= '0;
      out_space_r  <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.err_code;
    end else if (res_load) begin
      out_mark_r   <= j_r[0] ? mark_r : g_dur;
      out_space_r  <= j_r[0] ? g_dur[12:0] : 13'd0;
      out_last_r   <= res_last;
      out_status_r <= ST_OK;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mark_us  = out_mark_r;
  assign out_space_us = out_space_r;
  assign out_last     = out_last_r;
  assign out_status   = out_status_r;

  // Longest frame has 99 durations
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n) j_r <= 7'd99)
    else $error("irfe_dp: duration index out of range");
  // Runs never exceed three half-bits
  a_units: assert property (@(posedge clk) disable iff (!rst_n) units_r <= 3'd3)
    else $error("irfe_dp: run too long");
  // Error results carry no duration and end the message
  a_err_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_mark_r == 14'd0 && out_last_r))
    else $error("irfe_dp: malformed error result");
  // A result is never loaded over one that is still waiting
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load || cmd.err_load) |-> (!out_valid_r || out_ready))
    else $error("irfe_dp: result overwritten");

endmodule

`default_nettype wire

// ----- rtl/ir_remote_frame_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit - IR remote frame encoder top level
// Turns one remote message into mark/space duration pairs.
// ----------------------------------------------------------------------------
// Flow (frames of up to 99 durations): the message is captured, the single duration
//   walker runs once to count, the count is checked against capacity, and the walker
//   runs again to emit; Manchester passes take one step per half-bit (28 or 44) plus
//   one per leader or closing run; emission holds while the output stalls. Messages
//   are taken one at a time; a failed check or bad protocol gives an error result.
// Reset: synchronous active-low; capacity register returns to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_remote_frame_encoder_unit import irfe_pkg::*; #(
  parameter logic [7:0] MaxDurReset = MAX_DUR_RESET
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  irfe_in_if.sink          in_ch,
  irfe_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  irfe_cmd_t  cmd;
  irfe_sts_t  sts;
  logic [7:0] max_dur_r;
  logic       in_fire;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r <= MaxDurReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MAX_DUR) begin
      max_dur_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_DUR) ? {24'd0, max_dur_r} : 32'd0;

  assign in_fire = in_ch.valid && in_ch.ready;

  irfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  irfe_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .max_dur       (max_dur_r),
    .in_protocol   (in_ch.protocol),
    .in_address    (in_ch.address),
    .in_command    (in_ch.command),
    .in_repeat_req (in_ch.repeat_req),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_mark_us   (out_ch.mark_us),
    .out_space_us  (out_ch.space_us),
    .out_last      (out_ch.last),
    .out_status    (out_ch.status)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - IR remote frame encoder unit test
// Sends remote messages of every protocol and checks each mark/space pair
// against an in-bench frame builder, across several capacity settings, with
// bursty input and stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import irfe_pkg::*;

  localparam logic [3:0] PROTO_BAD_LO = 4'd10;
  localparam logic [3:0] PROTO_BAD_HI = 4'd15;
  localparam int         IDLE_LIMIT   = 20000;
  localparam int         DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [13:0] mark;
    logic [12:0] space;
    logic        last;
    logic [1:0]  status;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  irfe_in_if  in_ch ();
  irfe_out_if out_ch ();

  ir_remote_frame_encoder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // Bench copy of the capacity register and expected pairs
  logic [7:0]  capacity = MAX_DUR_RESET;
  pair_t       pair_q[$];
  int unsigned durs[$];
  int          fail_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          stall_age = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.protocol = '0;
    in_ch.address = '0;
    in_ch.command = '0;
    in_ch.repeat_req = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Pulse-distance body: header, one mark plus data space per bit, stop mark
  function automatic void add_pulse_distance(int unsigned hm, int unsigned hs,
      int unsigned mk, int unsigned s0, int unsigned s1, logic [63:0] v, int nb,
      int unsigned stop);
    durs.push_back(hm);
    durs.push_back(hs);
    for (int i = 0; i < nb; i++) begin
      durs.push_back(mk);
      durs.push_back(v[i] ? s1 : s0);
    end
    durs.push_back(stop);
  endfunction

  // Merge equal Manchester half-bits into runs, dropping edge spaces
  function automatic void add_runs(logic [43:0] hl, int nh, int unsigned half);
    int i;
    int units;
    logic lvl;
    i = 0;
    while (i < nh && !hl[i]) i++;
    while (i < nh) begin
      lvl = hl[i];
      units = 0;
      while (i < nh && hl[i] == lvl) begin
        units++;
        i++;
      end
      if (!lvl && i >= nh) break;
      durs.push_back(units * half);
    end
  endfunction

  // Build the frame of one message and queue its expected pairs
  function automatic void predict_frame(logic [3:0] proto, logic [23:0] addr,
      logic [23:0] cmd, logic rep);
    logic [63:0] v;
    logic [23:0] raw;
    logic [43:0] hl;
    logic [1:0]  st;
    int          p;
    int          nb;
    int          n;
    int          nres;
    pair_t       r;
    durs.delete();
    v = '0;
    hl = '0;
    st = ST_OK;
    case (proto)
      PROTO_NEC, PROTO_NECEXT: begin
        if (rep) begin
          durs.push_back(9000);
          durs.push_back(2250);
          durs.push_back(560);
        end else begin
          if (proto == PROTO_NEC)
            v = {32'd0, ~cmd[7:0], cmd[7:0], ~addr[7:0], addr[7:0]};
          else
            v = {32'd0, cmd[15:0], addr[15:0]};
          add_pulse_distance(9000, 4500, 560, 560, 1690, v, 32, 560);
        end
      end
      PROTO_SAMSUNG: begin
        v = {32'd0, ~cmd[7:0], cmd[7:0], addr[7:0], addr[7:0]};
        add_pulse_distance(4500, 4500, 550, 550, 1650, v, 32, 550);
      end
      PROTO_SIRC12, PROTO_SIRC15, PROTO_SIRC20: begin
        nb = (proto == PROTO_SIRC12) ? 12 : (proto == PROTO_SIRC15) ? 15 : 20;
        v = {33'd0, addr, cmd[6:0]};
        durs.push_back(2400);
        durs.push_back(600);
        for (int i = 0; i < nb; i++) begin
          durs.push_back(v[i] ? 1200 : 600);
          if (i + 1 < nb) durs.push_back(600);
        end
      end
      PROTO_RCA: begin
        raw = {addr[3:0], cmd[7:0], ~addr[3:0], ~cmd[7:0]};
        for (int i = 0; i < 24; i++) v[23 - i] = raw[i];
        add_pulse_distance(4000, 4000, 500, 1000, 2000, v, 24, 500);
      end
      PROTO_RC5: begin
        // start bit, S2 (cleared by command bit 6), toggle 0, address, command
        v = {50'd0, 1'b1, ~cmd[6], 1'b0, addr[4:0], cmd[5:0]};
        for (int i = 0; i < 14; i++) begin
          hl[2 * i]     = ~v[13 - i];
          hl[2 * i + 1] = v[13 - i];
        end
        add_runs(hl, 28, 889);
      end
      PROTO_RC6: begin
        // leader durations, start, mode 000, double-width trailer
        hl[11:0] = 12'b1100_1010_1001;
        v = {48'd0, addr[7:0], cmd[7:0]};
        p = 12;
        for (int i = 0; i < 16; i++) begin
          hl[p]     = v[15 - i];
          hl[p + 1] = ~v[15 - i];
          p += 2;
        end
        durs.push_back(2666);
        durs.push_back(889);
        add_runs(hl, 44, 444);
      end
      PROTO_KASEIKYO: begin
        v = {16'd0, cmd, addr};
        add_pulse_distance(3456, 1728, 432, 432, 1296, v, 48, 432);
      end
      default: st = ST_UNSUP;
    endcase
    n = durs.size();
    if (st == ST_OK && (n > capacity || n == 0)) st = ST_OVF;
    if (st != ST_OK) begin
      r = '{mark: '0, space: '0, last: 1'b1, status: st};
      pair_q.push_back(r);
    end else begin
      nres = (n + 1) / 2;
      for (int k = 0; k < nres; k++) begin
        r.mark   = 14'(durs[2 * k]);
        r.space  = (2 * k + 1 < n) ? 13'(durs[2 * k + 1]) : 13'd0;
        r.last   = (k + 1 == nres);
        r.status = ST_OK;
        pair_q.push_back(r);
      end
    end
  endfunction

  // Send one message; bursts of random length separated by random gaps
  task automatic send_msg(logic [3:0] proto, logic [23:0] addr, logic [23:0] cmd,
      logic rep);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.protocol <= proto;
    in_ch.address <= addr;
    in_ch.command <= cmd;
    in_ch.repeat_req <= rep;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_frame(proto, addr, cmd, rep);
    burst_left--;
  endtask

  // Drop valid and wait for every expected pair, then let the block settle
  task automatic drain;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pair_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Capacity register write: setup then access cycle, only while idle
  task automatic write_capacity(logic [7:0] cap, logic [23:0] junk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(4 * REG_MAX_DUR);
    cfg_pwdata <= {junk, cap};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    capacity = cap;
  endtask

  function automatic logic [3:0] pick_protocol;
    if ($urandom_range(0, 15) == 0) return 4'($urandom_range(PROTO_BAD_LO, PROTO_BAD_HI));
    return 4'($urandom_range(PROTO_NEC, PROTO_KASEIKYO));
  endfunction

  task automatic test_directed;
    send_msg(PROTO_NEC, 24'h000000, 24'h000000, 1'b0);
    send_msg(PROTO_NEC, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_msg(PROTO_NEC, 24'h123456, 24'h654321, 1'b1);
    send_msg(PROTO_NECEXT, 24'hA5C3F0, 24'h0F5A33, 1'b0);
    send_msg(PROTO_NECEXT, 24'hFFFFFF, 24'h000000, 1'b1);
    send_msg(PROTO_SAMSUNG, 24'h000007, 24'hFFFF02, 1'b0);
    send_msg(PROTO_SAMSUNG, 24'hFFFFFF, 24'h000000, 1'b1);   // repeat ignored
    send_msg(PROTO_SIRC12, 24'h000000, 24'h000000, 1'b0);
    send_msg(PROTO_SIRC12, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_msg(PROTO_SIRC15, 24'h0000AB, 24'h000055, 1'b1);
    send_msg(PROTO_SIRC20, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_msg(PROTO_SIRC20, 24'h000000, 24'h000000, 1'b0);
    send_msg(PROTO_RCA, 24'h00000F, 24'h0000FF, 1'b0);
    send_msg(PROTO_RCA, 24'hFFFFF0, 24'hFFFF00, 1'b1);
    send_msg(PROTO_RC5, 24'h000000, 24'h000000, 1'b0);
    send_msg(PROTO_RC5, 24'hFFFFFF, 24'hFFFFFF, 1'b0);       // extended command
    send_msg(PROTO_RC5, 24'h000015, 24'h00002A, 1'b1);
    send_msg(PROTO_RC6, 24'h000000, 24'h000000, 1'b0);
    send_msg(PROTO_RC6, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_msg(PROTO_RC6, 24'h0000A5, 24'h00005A, 1'b1);
    send_msg(PROTO_KASEIKYO, 24'h000000, 24'hFFFFFF, 1'b0);
    send_msg(PROTO_KASEIKYO, 24'hFFFFFF, 24'h000000, 1'b1);
    send_msg(PROTO_BAD_LO, 24'h123456, 24'h789ABC, 1'b0);
    send_msg(PROTO_BAD_HI, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    drain();
  endtask

  // Capacity edges: zero, repeat code boundary, longest frame boundary
  task automatic test_capacity;
    logic [7:0] caps[5] = '{8'd0, 8'd2, 8'd3, 8'd98, 8'd99};
    foreach (caps[c]) begin
      write_capacity(caps[c], 24'($urandom));
      send_msg(PROTO_NEC, 24'($urandom), 24'($urandom), 1'b1);
      send_msg(PROTO_KASEIKYO, 24'($urandom), 24'($urandom), 1'b0);
      send_msg(PROTO_RC5, 24'($urandom), 24'($urandom), 1'b0);
      send_msg(PROTO_BAD_LO, 24'($urandom), 24'($urandom), 1'b0);
      drain();
    end
  endtask

  task automatic test_random;
    logic [7:0] caps[4];
    caps[0] = 8'd255;
    caps[1] = 8'($urandom_range(3, 99));
    caps[2] = 8'($urandom_range(20, 70));
    caps[3] = 8'($urandom_range(100, 254));
    foreach (caps[c]) begin
      write_capacity(caps[c], 24'($urandom));
      repeat (34)
        send_msg(pick_protocol(), 24'($urandom), 24'($urandom), 1'($urandom));
      drain();
    end
    write_capacity(MAX_DUR_RESET, 24'd0);
  endtask

  // Receiver stalls, result checking and the idle watchdog
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pair_q.size() == 0) begin
        $error("unexpected result: mark %0d space %0d", out_ch.mark_us, out_ch.space_us);
        fail_count++;
      end else begin
        want = pair_q.pop_front();
        if (out_ch.mark_us !== want.mark) begin
          $error("mark_us expected %0d got %0d", want.mark, out_ch.mark_us);
          fail_count++;
        end
        if (out_ch.space_us !== want.space) begin
          $error("space_us expected %0d got %0d", want.space, out_ch.space_us);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last expected %0d got %0d", want.last, out_ch.last);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_ch.status);
          fail_count++;
        end
      end
    end
    if (stall_age == 80) begin
      stall_mode <= $urandom_range(0, 2);
      stall_age <= 0;
    end else begin
      stall_age <= stall_age + 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ir_remote_frame_encoder_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random();
    if (fail_count == 0) begin
      $display("ir_remote_frame_encoder_unit verification clean");
    end else begin
      $display("ir_remote_frame_encoder_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
